// File: design/mdt_pkg.sv
// Package for the minimum decision tree block: constants, node kind codes,
// controller state type and the power-of-three helper.
// No dependencies.
package mdt_pkg;

  localparam int DEF_NUM_VARS = 5;
  localparam int FIELD_W      = 5;
  localparam int TABLE_W      = 32;
  localparam int COST_W       = 6;
  localparam int SPLIT_W      = 3;
  localparam int KIND_W       = 2;

  localparam logic [COST_W-1:0] COST_ZERO = 6'd62;
  localparam logic [COST_W-1:0] COST_ONE  = 6'd63;
  localparam logic [COST_W:0]   COST_INF  = 7'h7F;

  localparam logic [1:0] DIG_ONE  = 2'd1;
  localparam logic [1:0] DIG_FREE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SPLIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEAF0 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LEAF1 = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SOLVE,
    ST_WALK_RD,
    ST_WALK_EMIT
  } state_t;

  function automatic int pow3(input int n);
    int r;
    r = 1;
    for (int k = 0; k < n; k++) r = r * 3;
    return r;
  endfunction

endpackage

// File: design/min_decision_tree_dp.sv
// Minimum decision tree solver: subcube cost memories, bottom-up solver and preorder walk.
// Depends on mdt_pkg.
//
//  port group   direction  handshake                 payload
//  in_          in         start & !busy             in_truth_table
//  out_         out        out_valid (1-cycle pulse) fixed_mask, fixed_values, node_kind,
//                                                    split_variable, tree_size, is_last
//
// Solve: 3^NUM_VARS subcubes, each taking one child-cost read pair per variable on the
// cost memory, then one write-back.
// Walk: a memory read state then an emit state per node, up to 63 nodes at five variables.
// Busy stays high throughout an item's solve and walk.
// Reset clears control only; every memory entry is written before it is read.
// Results are strobed for one cycle and cannot be stalled.
module min_decision_tree_dp #(
  parameter int NUM_VARS = mdt_pkg::DEF_NUM_VARS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [mdt_pkg::TABLE_W-1:0]         in_truth_table,
  output logic                                out_valid,
  output logic [mdt_pkg::FIELD_W-1:0]         out_fixed_mask,
  output logic [mdt_pkg::FIELD_W-1:0]         out_fixed_values,
  output logic [mdt_pkg::KIND_W-1:0]          out_node_kind,
  output logic [mdt_pkg::SPLIT_W-1:0]         out_split_variable,
  output logic [mdt_pkg::FIELD_W-1:0]         out_tree_size,
  output logic                                out_is_last
);

  localparam int NCUBES  = mdt_pkg::pow3(NUM_VARS);
  localparam int AW      = $clog2(NCUBES);
  localparam int VW      = $clog2(NUM_VARS + 1);
  localparam int IW      = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int SD      = NUM_VARS + 1;
  localparam int SPW     = $clog2(SD + 1);
  localparam int SIW     = $clog2(SD);
  localparam int MAX_RES = (2 ** (NUM_VARS + 1)) - 1;
  localparam int CW      = $clog2(MAX_RES + 1);
  localparam int FW      = mdt_pkg::FIELD_W;
  localparam int CSW     = mdt_pkg::COST_W;
  localparam int SW      = mdt_pkg::SPLIT_W;

  mdt_pkg::state_t state_r, state_nxt;

  logic [mdt_pkg::TABLE_W-1:0] table_r, table_nxt;
  logic [AW-1:0]  u_r, u_nxt;
  logic [VW-1:0]  vi_r, vi_nxt;
  logic [SW-1:0]  rd_var_r, rd_var_nxt;
  logic           rd_free_r, rd_free_nxt;
  logic [CSW:0]   best_r, best_nxt;
  logic [SW-1:0]  split_r, split_nxt;
  logic           done_r, done_nxt;
  logic [1:0]     dig_r [NUM_VARS];
  logic [1:0]     dig_nxt [NUM_VARS];
  logic [FW-1:0]  size_r, size_nxt;

  logic [AW-1:0]  stk_idx_r [SD];
  logic [AW-1:0]  stk_idx_nxt [SD];
  logic [FW-1:0]  stk_mask_r [SD];
  logic [FW-1:0]  stk_mask_nxt [SD];
  logic [FW-1:0]  stk_vals_r [SD];
  logic [FW-1:0]  stk_vals_nxt [SD];
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  cur_idx_r, cur_idx_nxt;
  logic [FW-1:0]  cur_mask_r, cur_mask_nxt;
  logic [FW-1:0]  cur_vals_r, cur_vals_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [FW-1:0]               out_mask_r, out_mask_nxt;
  logic [FW-1:0]               out_vals_r, out_vals_nxt;
  logic [mdt_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [SW-1:0]               out_var_r, out_var_nxt;
  logic [FW-1:0]               out_size_r, out_size_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [CSW-1:0] cost_mem [NCUBES];
  logic [SW-1:0]  split_mem [NCUBES];
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  logic [CSW-1:0] mem_wcost;
  logic [SW-1:0]  mem_wsplit;
  logic [AW-1:0]  ra0, ra1;
  logic [CSW-1:0] cost0_r, cost1_r;
  logic [SW-1:0]  split_rd_r;

  logic [AW-1:0]  pow3_w [NUM_VARS];
  logic [AW-1:0]  pow3x2_w [NUM_VARS];

  logic [CSW:0]   ev_best;
  logic [SW-1:0]  ev_split;
  logic           ev_done;
  logic           any_free;
  logic [FW-1:0]  leaf_t;
  logic [SPW-1:0] sp_m1;
  logic [SIW-1:0] top_i;

  for (genvar g = 0; g < NUM_VARS; g++) begin : g_pow3
    assign pow3_w[g]   = AW'(mdt_pkg::pow3(g));
    assign pow3x2_w[g] = AW'(2 * mdt_pkg::pow3(g));
  end

  assign sp_m1 = sp_r - SPW'(1);
  assign top_i = sp_m1[SIW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cost_mem[mem_wa]  <= mem_wcost;
      split_mem[mem_wa] <= mem_wsplit;
    end
    cost0_r    <= cost_mem[ra0];
    cost1_r    <= cost_mem[ra1];
    split_rd_r <= split_mem[ra0];
  end

  always_comb begin
    logic cl_c;
    logic cr_c;
    logic [CSW:0] tmp;
    cl_c = (cost0_r[CSW-1:1] == mdt_pkg::COST_ZERO[CSW-1:1]);
    cr_c = (cost1_r[CSW-1:1] == mdt_pkg::COST_ZERO[CSW-1:1]);
    tmp  = (CSW+1)'(1) + (cl_c ? (CSW+1)'(0) : {1'b0, cost0_r})
         + (cr_c ? (CSW+1)'(0) : {1'b0, cost1_r});
    ev_best  = best_r;
    ev_split = split_r;
    ev_done  = done_r;
    if (rd_free_r && !done_r) begin
      if (cl_c && (cost0_r == cost1_r)) begin
        ev_best  = {1'b0, cost0_r};
        ev_split = '0;
        ev_done  = 1'b1;
      end else if (cl_c && cr_c) begin
        ev_best  = (CSW+1)'(1);
        ev_split = rd_var_r;
        ev_done  = 1'b1;
      end else if (tmp < best_r) begin
        ev_best  = tmp;
        ev_split = rd_var_r;
      end
    end
  end

  always_comb begin
    any_free = 1'b0;
    leaf_t   = '0;
    for (int k = 0; k < NUM_VARS; k++) begin
      if (dig_r[k] == mdt_pkg::DIG_FREE) any_free = 1'b1;
      if (dig_r[k] == mdt_pkg::DIG_ONE) leaf_t[k] = 1'b1;
    end
  end

  always_comb begin
    logic           carry;
    logic [IW-1:0]  vidx;
    logic           fr;
    logic [SPW-1:0] sp_a;
    logic [IW-1:0]  si;
    logic [FW-1:0]  sbit;
    logic           last;
    state_nxt     = state_r;
    table_nxt     = table_r;
    u_nxt         = u_r;
    vi_nxt        = vi_r;
    rd_var_nxt    = rd_var_r;
    rd_free_nxt   = rd_free_r;
    best_nxt      = best_r;
    split_nxt     = split_r;
    done_nxt      = done_r;
    dig_nxt       = dig_r;
    size_nxt      = size_r;
    stk_idx_nxt   = stk_idx_r;
    stk_mask_nxt  = stk_mask_r;
    stk_vals_nxt  = stk_vals_r;
    sp_nxt        = sp_r;
    cnt_nxt       = cnt_r;
    cur_idx_nxt   = cur_idx_r;
    cur_mask_nxt  = cur_mask_r;
    cur_vals_nxt  = cur_vals_r;
    out_valid_nxt = 1'b0;
    out_mask_nxt  = out_mask_r;
    out_vals_nxt  = out_vals_r;
    out_kind_nxt  = out_kind_r;
    out_var_nxt   = out_var_r;
    out_size_nxt  = out_size_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wa        = u_r;
    mem_wcost     = ev_best[CSW-1:0];
    mem_wsplit    = ev_split;
    ra0           = u_r;
    ra1           = u_r;
    carry         = 1'b1;
    vidx          = vi_r[IW-1:0];
    fr            = 1'b0;
    sp_a          = sp_r;
    si            = split_rd_r[IW-1:0];
    sbit          = FW'(1) << split_rd_r;
    last          = 1'b0;

    unique case (state_r)
      mdt_pkg::ST_IDLE: begin
        if (start) begin
          table_nxt   = in_truth_table;
          u_nxt       = '0;
          vi_nxt      = '0;
          rd_free_nxt = 1'b0;
          best_nxt    = mdt_pkg::COST_INF;
          split_nxt   = '0;
          done_nxt    = 1'b0;
          for (int k = 0; k < NUM_VARS; k++) dig_nxt[k] = '0;
          state_nxt   = mdt_pkg::ST_SOLVE;
        end
      end

      mdt_pkg::ST_SOLVE: begin
        best_nxt  = ev_best;
        split_nxt = ev_split;
        done_nxt  = ev_done;
        if (vi_r < VW'(NUM_VARS)) begin
          fr          = (dig_r[vidx] == mdt_pkg::DIG_FREE);
          ra0         = fr ? u_r - pow3x2_w[vidx] : u_r;
          ra1         = fr ? u_r - pow3_w[vidx] : u_r;
          rd_free_nxt = fr;
          rd_var_nxt  = SW'(vidx);
          vi_nxt      = vi_r + VW'(1);
        end else begin
          mem_we = 1'b1;
          if (!any_free) begin
            mem_wcost  = table_r[leaf_t] ? mdt_pkg::COST_ONE : mdt_pkg::COST_ZERO;
            mem_wsplit = '0;
          end
          rd_free_nxt = 1'b0;
          best_nxt    = mdt_pkg::COST_INF;
          split_nxt   = '0;
          done_nxt    = 1'b0;
          vi_nxt      = '0;
          if (u_r == AW'(NCUBES - 1)) begin
            size_nxt = (mem_wcost[CSW-1:1] == mdt_pkg::COST_ZERO[CSW-1:1]) ?
                       '0 : mem_wcost[FW-1:0];
            stk_idx_nxt[0]  = u_r;
            stk_mask_nxt[0] = '0;
            stk_vals_nxt[0] = '0;
            sp_nxt          = SPW'(1);
            cnt_nxt         = '0;
            state_nxt       = mdt_pkg::ST_WALK_RD;
          end else begin
            u_nxt = u_r + AW'(1);
            for (int k = 0; k < NUM_VARS; k++) begin
              if (carry) begin
                if (dig_r[k] == mdt_pkg::DIG_FREE) begin
                  dig_nxt[k] = '0;
                end else begin
                  dig_nxt[k] = dig_r[k] + 2'd1;
                  carry      = 1'b0;
                end
              end
            end
          end
        end
      end

      mdt_pkg::ST_WALK_RD: begin
        ra0          = stk_idx_r[top_i];
        cur_idx_nxt  = stk_idx_r[top_i];
        cur_mask_nxt = stk_mask_r[top_i];
        cur_vals_nxt = stk_vals_r[top_i];
        sp_nxt       = sp_m1;
        state_nxt    = mdt_pkg::ST_WALK_EMIT;
      end

      mdt_pkg::ST_WALK_EMIT: begin
        out_valid_nxt = 1'b1;
        out_mask_nxt  = cur_mask_r;
        out_vals_nxt  = cur_vals_r;
        out_size_nxt  = size_r;
        if (cost0_r[CSW-1:1] == mdt_pkg::COST_ZERO[CSW-1:1]) begin
          out_kind_nxt = (cost0_r == mdt_pkg::COST_ONE) ?
                         mdt_pkg::KIND_LEAF1 : mdt_pkg::KIND_LEAF0;
          out_var_nxt  = '0;
        end else begin
          out_kind_nxt = mdt_pkg::KIND_SPLIT;
          out_var_nxt  = split_rd_r;
          if (split_rd_r < SW'(NUM_VARS)) begin
            if (sp_a < SPW'(SD)) begin
              stk_idx_nxt[sp_a[SIW-1:0]]  = cur_idx_r - pow3_w[si];
              stk_mask_nxt[sp_a[SIW-1:0]] = cur_mask_r | sbit;
              stk_vals_nxt[sp_a[SIW-1:0]] = cur_vals_r | sbit;
              sp_a = sp_a + SPW'(1);
            end
            if (sp_a < SPW'(SD)) begin
              stk_idx_nxt[sp_a[SIW-1:0]]  = cur_idx_r - pow3x2_w[si];
              stk_mask_nxt[sp_a[SIW-1:0]] = cur_mask_r | sbit;
              stk_vals_nxt[sp_a[SIW-1:0]] = cur_vals_r;
              sp_a = sp_a + SPW'(1);
            end
          end
        end
        last         = (sp_a == '0) || (cnt_r == CW'(MAX_RES - 1));
        out_last_nxt = last;
        sp_nxt       = sp_a;
        cnt_nxt      = cnt_r + CW'(1);
        state_nxt    = last ? mdt_pkg::ST_IDLE : mdt_pkg::ST_WALK_RD;
      end

      default: begin
        state_nxt = mdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mdt_pkg::ST_IDLE;
      sp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    table_r    <= table_nxt;
    u_r        <= u_nxt;
    vi_r       <= vi_nxt;
    rd_var_r   <= rd_var_nxt;
    rd_free_r  <= rd_free_nxt;
    best_r     <= best_nxt;
    split_r    <= split_nxt;
    done_r     <= done_nxt;
    dig_r      <= dig_nxt;
    size_r     <= size_nxt;
    stk_idx_r  <= stk_idx_nxt;
    stk_mask_r <= stk_mask_nxt;
    stk_vals_r <= stk_vals_nxt;
    cur_idx_r  <= cur_idx_nxt;
    cur_mask_r <= cur_mask_nxt;
    cur_vals_r <= cur_vals_nxt;
    out_mask_r <= out_mask_nxt;
    out_vals_r <= out_vals_nxt;
    out_kind_r <= out_kind_nxt;
    out_var_r  <= out_var_nxt;
    out_size_r <= out_size_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy               = (state_r != mdt_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_fixed_mask     = out_mask_r;
  assign out_fixed_values   = out_vals_r;
  assign out_node_kind      = out_kind_r;
  assign out_split_variable = out_var_r;
  assign out_tree_size      = out_size_r;
  assign out_is_last        = out_last_r;

  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> busy)
    else $error("result before the last node while controller idle");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_leaf_var: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_node_kind != mdt_pkg::KIND_SPLIT) |-> out_split_variable == '0)
    else $error("leaf result with nonzero split variable");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(SD))
    else $error("walk stack pointer beyond depth");

endmodule
